// ----- rtl/odo_pkg.sv -----
package odo_pkg;

  // Fixed-point angle constants, Q16.16 radians
  localparam logic signed [63:0] PI_Q16      = 64'sd205887;
  localparam logic signed [63:0] TWO_PI_Q16  = 64'sd411775;
  localparam logic signed [18:0] HALF_PI_Q16 = 19'sd102944;

  // CORDIC fixed gain, Q2.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Size of the arctangent table
  localparam int unsigned ATAN_ENTRIES = 30;

  typedef enum logic [1:0] {
    MODE_WHEEL   = 2'd0,
    MODE_VEL     = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_HOLD    = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    REG_WHEEL_RADIUS = 4'd0,
    REG_HALF_TRACK   = 4'd1,
    REG_MAX_RATE     = 4'd2,
    REG_STEP_TIME    = 4'd3,
    REG_WHEELS_READY = 4'd4,
    REG_START_X      = 4'd5,
    REG_START_Y      = 4'd6,
    REG_START_THETA  = 4'd7
  } cfg_reg_e;

  // Divider request and response
  typedef struct packed {
    logic               start;
    logic signed [63:0] dividend;
    logic [31:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [63:0] quo;
    logic signed [32:0] rem;
  } div_rsp_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] res;
    case (idx)
      5'd0:    res = 34'sd843314857;
      5'd1:    res = 34'sd497837829;
      5'd2:    res = 34'sd263043837;
      5'd3:    res = 34'sd133525159;
      5'd4:    res = 34'sd67021687;
      5'd5:    res = 34'sd33543516;
      5'd6:    res = 34'sd16775851;
      5'd7:    res = 34'sd8388437;
      5'd8:    res = 34'sd4194283;
      5'd9:    res = 34'sd2097149;
      5'd10:   res = 34'sd1048576;
      5'd11:   res = 34'sd524288;
      5'd12:   res = 34'sd262144;
      5'd13:   res = 34'sd131072;
      5'd14:   res = 34'sd65536;
      5'd15:   res = 34'sd32768;
      5'd16:   res = 34'sd16384;
      5'd17:   res = 34'sd8192;
      5'd18:   res = 34'sd4096;
      5'd19:   res = 34'sd2048;
      5'd20:   res = 34'sd1024;
      5'd21:   res = 34'sd512;
      5'd22:   res = 34'sd256;
      5'd23:   res = 34'sd128;
      5'd24:   res = 34'sd64;
      5'd25:   res = 34'sd32;
      5'd26:   res = 34'sd16;
      5'd27:   res = 34'sd8;
      5'd28:   res = 34'sd4;
      5'd29:   res = 34'sd2;
      default: res = 34'sd0;
    endcase
    return res;
  endfunction

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/odo_mul.sv -----
module odo_mul (
  input  logic               clk_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] p_o
);

  logic signed [67:0] p_q;

  // Register the product
  always_ff @(posedge clk_i) begin
    p_q <= 68'(a_i) * 68'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- rtl/odo_div.sv -----
module odo_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  odo_pkg::div_req_t req_i,
  output odo_pkg::div_rsp_t rsp_o
);

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [63:0] quo_q;
  logic [32:0] rem_q;
  logic [31:0] dvs_q;

  logic [63:0] mag;
  logic [32:0] shifted;
  logic        fits;

  // Work on magnitudes, restore the sign at the output
  assign mag     = req_i.dividend[63] ? 64'(-req_i.dividend) : 64'(req_i.dividend);
  assign shifted = {rem_q[31:0], quo_q[63]};
  assign fits    = shifted >= {1'b0, dvs_q};

  // Control: one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring shift-subtract
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quo_q <= mag;
      rem_q <= '0;
      neg_q <= req_i.dividend[63];
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], fits};
      rem_q <= fits ? (shifted - {1'b0, dvs_q}) : shifted;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign rsp_o.rem  = neg_q ? -$signed(rem_q) : $signed(rem_q);

endmodule

// ----- rtl/odo_cordic.sv -----
module odo_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [18:0] angle_i,
  output logic               busy_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam logic [4:0] LastIdx = 5'(CORDIC_STEPS - 1);

  logic               busy_q, neg_q;
  logic [4:0]         idx_q;
  logic signed [33:0] x_q, y_q, z_q;

  logic signed [18:0] red;
  logic               red_neg;
  logic signed [33:0] dx, dy, ang;

  // Fold the heading into the right half plane
  always_comb begin
    red     = angle_i;
    red_neg = 1'b0;
    if (angle_i > odo_pkg::HALF_PI_Q16) begin
      red     = angle_i - odo_pkg::PI_Q16[18:0];
      red_neg = 1'b1;
    end else if (angle_i < -odo_pkg::HALF_PI_Q16) begin
      red     = angle_i + odo_pkg::PI_Q16[18:0];
      red_neg = 1'b1;
    end
  end

  assign dx  = y_q >>> idx_q;
  assign dy  = x_q >>> idx_q;
  assign ang = odo_pkg::atan_q30(idx_q);

  // Iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q) begin
      idx_q <= idx_q + 5'd1;
      if (idx_q == LastIdx) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Rotate toward zero residual angle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= odo_pkg::CORDIC_GAIN;
      y_q   <= '0;
      z_q   <= 34'(red) <<< 14;
      neg_q <= red_neg;
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + ang;
      end
    end
  end

  assign busy_o = busy_q;
  assign cos_o  = neg_q ? -x_q : x_q;
  assign sin_o  = neg_q ? -y_q : y_q;

endmodule

// ----- rtl/differential_drive_odometry.sv -----
// Differential-drive odometry in Q16.16. One command is taken at a time; the block is
// not ready until its pose result has been handed to the output register. Work runs
// through one registered multiplier and one divider that yields one quotient bit per
// cycle while it is busy. A command runs n divisions, with n = 0 for mode 3 or a
// refused command, 1 for a pose restart, 2 for a wheel rate command, 4 when the rates
// are scaled down, and 2 more for a velocity command. The heading CORDIC runs
// alongside the divider. The configuration channel is always ready; the user must see
// that it is written only while the block is idle: the block does not enforce this.
module differential_drive_odometry #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // cmd_a [31:0], cmd_b [63:32]
  input  logic [1:0]  s_axis_tuser,   // mode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // pos_x [31:0], pos_y [63:32], heading [82:64]
  output logic [1:0]  m_axis_tuser,   // rates_scaled [0], not_ready [1]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [24:0] {
    S_IDLE    = 25'd1 << 0,
    S_V2W_MUL = 25'd1 << 1,
    S_V2W_DL  = 25'd1 << 2,
    S_V2W_WL  = 25'd1 << 3,
    S_V2W_WR  = 25'd1 << 4,
    S_SC_CHK  = 25'd1 << 5,
    S_SC_ML   = 25'd1 << 6,
    S_SC_DL   = 25'd1 << 7,
    S_SC_WL   = 25'd1 << 8,
    S_SC_MR   = 25'd1 << 9,
    S_SC_DR   = 25'd1 << 10,
    S_SC_WR   = 25'd1 << 11,
    S_VW_MUL  = 25'd1 << 12,
    S_VW_V    = 25'd1 << 13,
    S_VW_DO   = 25'd1 << 14,
    S_VW_WO   = 25'd1 << 15,
    S_CS_WAIT = 25'd1 << 16,
    S_XY_MC   = 25'd1 << 17,
    S_XY_MS   = 25'd1 << 18,
    S_XY_T1   = 25'd1 << 19,
    S_XY_T2   = 25'd1 << 20,
    S_XY_T3   = 25'd1 << 21,
    S_TH      = 25'd1 << 22,
    S_WRAP_W  = 25'd1 << 23,
    S_DONE    = 25'd1 << 24
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [30:0]        radius_q, half_track_q, max_rate_q;
  logic [15:0]        step_q;
  logic               wheels_ready_q;
  logic signed [31:0] start_x_q, start_y_q;
  logic signed [18:0] start_theta_q;

  // Command and working registers
  odo_pkg::mode_e     mode_q;
  logic signed [31:0] a_q, b_q, wl_q, wr_q, v_q, om_q;
  logic signed [63:0] acc_q;
  logic [31:0]        m_q;
  logic signed [33:0] vx_q, vy_q;
  logic               scaled_q, refused_q;

  // Pose
  logic signed [31:0] px_q, py_q;
  logic signed [18:0] ph_q;

  // Output register
  logic        out_valid_q;
  logic [87:0] out_data_q;
  logic [1:0]  out_user_q;

  logic               in_acc;
  odo_pkg::mode_e     in_mode;
  logic signed [31:0] in_a, in_b;
  logic [30:0]        r_eff, ht_eff;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [63:0] p64;
  odo_pkg::div_req_t  div_req;
  odo_pkg::div_rsp_t  div_rsp;
  logic               cs_start, cs_busy;
  logic signed [33:0] cs_cos, cs_sin;
  logic [31:0]        abs_l, abs_r, m_now;
  logic signed [33:0] wrap_rem, wrap_pos, wrap_head;
  logic               out_load;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_mode = odo_pkg::mode_e'(s_axis_tuser);
  assign in_a    = s_axis_tdata[31:0];
  assign in_b    = s_axis_tdata[63:32];

  // Zero geometry acts as one LSB
  assign r_eff  = (radius_q == '0) ? 31'd1 : radius_q;
  assign ht_eff = (half_track_q == '0) ? 31'd1 : half_track_q;

  assign p64 = mul_p[63:0];

  // Larger wheel-rate magnitude
  assign abs_l = wl_q[31] ? (~wl_q + 32'd1) : wl_q;
  assign abs_r = wr_q[31] ? (~wr_q + 32'd1) : wr_q;
  assign m_now = (abs_r > abs_l) ? abs_r : abs_l;

  // Floor-modulo fix-up for the heading wrap
  assign wrap_rem  = 34'(div_rsp.rem);
  assign wrap_pos  = wrap_rem[33] ? wrap_rem + 34'(odo_pkg::TWO_PI_Q16) : wrap_rem;
  assign wrap_head = wrap_pos - 34'(odo_pkg::PI_Q16);

  assign cs_start = (state_q == S_VW_MUL);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_V2W_MUL: begin
        mul_a = $signed({3'b0, ht_eff});
        mul_b = 34'(b_q);
      end
      S_SC_ML: begin
        mul_a = 34'(wl_q);
        mul_b = $signed({3'b0, max_rate_q});
      end
      S_SC_MR: begin
        mul_a = 34'(wr_q);
        mul_b = $signed({3'b0, max_rate_q});
      end
      S_VW_MUL: begin
        mul_a = $signed({3'b0, r_eff});
        mul_b = 34'(wl_q) + 34'(wr_q);
      end
      S_VW_V: begin
        mul_a = $signed({3'b0, r_eff});
        mul_b = 34'(wl_q) - 34'(wr_q);
      end
      S_XY_MC: begin
        mul_a = 34'(v_q);
        mul_b = cs_cos;
      end
      S_XY_MS: begin
        mul_a = 34'(v_q);
        mul_b = cs_sin;
      end
      S_XY_T1: begin
        mul_a = vx_q;
        mul_b = $signed({18'b0, step_q});
      end
      S_XY_T2: begin
        mul_a = vy_q;
        mul_b = $signed({18'b0, step_q});
      end
      S_XY_T3: begin
        mul_a = 34'(om_q);
        mul_b = $signed({18'b0, step_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider request select
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = 32'd1;
    case (state_q)
      S_IDLE: begin
        div_req.start    = in_acc && (in_mode == odo_pkg::MODE_RESTART);
        div_req.dividend = 64'(start_theta_q) + odo_pkg::PI_Q16;
        div_req.divisor  = odo_pkg::TWO_PI_Q16[31:0];
      end
      S_V2W_DL: begin
        div_req.start    = 1'b1;
        div_req.dividend = (64'(a_q) <<< 16) + p64;
        div_req.divisor  = {1'b0, r_eff};
      end
      S_V2W_WL: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = (64'(a_q) <<< 16) - acc_q;
        div_req.divisor  = {1'b0, r_eff};
      end
      S_SC_DL, S_SC_DR: begin
        div_req.start    = 1'b1;
        div_req.dividend = p64;
        div_req.divisor  = m_q;
      end
      S_VW_DO: begin
        div_req.start    = 1'b1;
        div_req.dividend = p64;
        div_req.divisor  = {ht_eff, 1'b0};
      end
      S_TH: begin
        div_req.start    = 1'b1;
        div_req.dividend = 64'(ph_q) + (p64 >>> 16) + odo_pkg::PI_Q16;
        div_req.divisor  = odo_pkg::TWO_PI_Q16[31:0];
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            odo_pkg::MODE_RESTART: state_d = S_WRAP_W;
            odo_pkg::MODE_WHEEL:   state_d = wheels_ready_q ? S_SC_CHK : S_DONE;
            odo_pkg::MODE_VEL:     state_d = wheels_ready_q ? S_V2W_MUL : S_DONE;
            default:               state_d = S_DONE;
          endcase
        end
      end
      S_V2W_MUL: state_d = S_V2W_DL;
      S_V2W_DL:  state_d = S_V2W_WL;
      S_V2W_WL:  if (div_rsp.done) state_d = S_V2W_WR;
      S_V2W_WR:  if (div_rsp.done) state_d = S_SC_CHK;
      S_SC_CHK:  state_d = (m_now > {1'b0, max_rate_q}) ? S_SC_ML : S_VW_MUL;
      S_SC_ML:   state_d = S_SC_DL;
      S_SC_DL:   state_d = S_SC_WL;
      S_SC_WL:   if (div_rsp.done) state_d = S_SC_MR;
      S_SC_MR:   state_d = S_SC_DR;
      S_SC_DR:   state_d = S_SC_WR;
      S_SC_WR:   if (div_rsp.done) state_d = S_VW_MUL;
      S_VW_MUL:  state_d = S_VW_V;
      S_VW_V:    state_d = S_VW_DO;
      S_VW_DO:   state_d = S_VW_WO;
      S_VW_WO:   if (div_rsp.done) state_d = S_CS_WAIT;
      S_CS_WAIT: if (!cs_busy) state_d = S_XY_MC;
      S_XY_MC:   state_d = S_XY_MS;
      S_XY_MS:   state_d = S_XY_T1;
      S_XY_T1:   state_d = S_XY_T2;
      S_XY_T2:   state_d = S_XY_T3;
      S_XY_T3:   state_d = S_TH;
      S_TH:      state_d = S_WRAP_W;
      S_WRAP_W:  if (div_rsp.done) state_d = S_DONE;
      S_DONE:    if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Control state, configuration and pose
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      radius_q       <= 31'd6554;
      half_track_q   <= 31'd16384;
      max_rate_q     <= 31'd655360;
      step_q         <= 16'd655;
      wheels_ready_q <= 1'b0;
      start_x_q      <= '0;
      start_y_q      <= '0;
      start_theta_q  <= '0;
      px_q           <= '0;
      py_q           <= '0;
      ph_q           <= '0;
      scaled_q       <= 1'b0;
      refused_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      // Register writes; unknown indexes drop
      if (cfg_valid_i) begin
        case (odo_pkg::cfg_reg_e'(cfg_index_i))
          odo_pkg::REG_WHEEL_RADIUS: radius_q       <= cfg_data_i[30:0];
          odo_pkg::REG_HALF_TRACK:   half_track_q   <= cfg_data_i[30:0];
          odo_pkg::REG_MAX_RATE:     max_rate_q     <= cfg_data_i[30:0];
          odo_pkg::REG_STEP_TIME:    step_q         <= cfg_data_i[15:0];
          odo_pkg::REG_WHEELS_READY: wheels_ready_q <= cfg_data_i[0];
          odo_pkg::REG_START_X:      start_x_q      <= cfg_data_i;
          odo_pkg::REG_START_Y:      start_y_q      <= cfg_data_i;
          odo_pkg::REG_START_THETA:  start_theta_q  <= cfg_data_i[18:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        scaled_q  <= 1'b0;
        refused_q <= 1'b0;
        if (in_mode == odo_pkg::MODE_RESTART) begin
          px_q <= start_x_q;
          py_q <= start_y_q;
        end else if ((in_mode == odo_pkg::MODE_WHEEL || in_mode == odo_pkg::MODE_VEL)
                     && !wheels_ready_q) begin
          refused_q <= 1'b1;
        end
      end

      if (state_q == S_SC_CHK && m_now > {1'b0, max_rate_q}) begin
        scaled_q <= 1'b1;
      end

      // Advance the pose
      if (state_q == S_XY_T2) begin
        px_q <= odo_pkg::sat32(64'(px_q) + (p64 >>> 16));
      end
      if (state_q == S_XY_T3) begin
        py_q <= odo_pkg::sat32(64'(py_q) + (p64 >>> 16));
      end
      if (state_q == S_WRAP_W && div_rsp.done) begin
        ph_q <= wrap_head[18:0];
      end

      // Output beat handshake
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= in_mode;
      a_q    <= in_a;
      b_q    <= in_b;
      wl_q   <= in_a;
      wr_q   <= in_b;
    end
    if (state_q == S_V2W_DL) begin
      acc_q <= p64;
    end
    if (state_q == S_V2W_WL && div_rsp.done) begin
      wl_q <= odo_pkg::sat32(div_rsp.quo);
    end
    if (state_q == S_V2W_WR && div_rsp.done) begin
      wr_q <= odo_pkg::sat32(div_rsp.quo);
    end
    if (state_q == S_SC_CHK) begin
      m_q <= m_now;
    end
    if (state_q == S_SC_WL && div_rsp.done) begin
      wl_q <= div_rsp.quo[31:0];
    end
    if (state_q == S_SC_WR && div_rsp.done) begin
      wr_q <= div_rsp.quo[31:0];
    end
    if (state_q == S_VW_V) begin
      v_q <= odo_pkg::sat32(p64 >>> 17);
    end
    if (state_q == S_VW_WO && div_rsp.done) begin
      om_q <= odo_pkg::sat32(div_rsp.quo);
    end
    if (state_q == S_XY_MS) begin
      vx_q <= 34'(p64 >>> 30);
    end
    if (state_q == S_XY_T1) begin
      vy_q <= 34'(p64 >>> 30);
    end
    if (out_load) begin
      out_data_q <= {5'b0, ph_q, py_q, px_q};
      out_user_q <= {refused_q, scaled_q};
    end
  end

  odo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  odo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  odo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cs_start),
    .angle_i (ph_q),
    .busy_o  (cs_busy),
    .cos_o   (cs_cos),
    .sin_o   (cs_sin)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  // A refused command is never also a scaled one
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("rates_scaled and not_ready both set");

  // Reported heading stays wrapped
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[82:64]) >= -19'sd205887 &&
                       $signed(m_axis_tdata[82:64]) <= 19'sd205887))
    else $error("heading out of range");

  // The sequencer never issues a division while one is running
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("division started while divider busy");

  // Pose products only use the CORDIC after it has finished
  a_cordic_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XY_MC) |-> !cs_busy)
    else $error("CORDIC result used while busy");
`endif

endmodule
